// ----- rtl/core/spicd_pkg.sv -----
// Shared types and constants for the serial clock divider search block.
package spicd_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ErrW = 7;
  localparam int unsigned PctScale = 100;
  // 32-bit difference times 100 fits in 39 bits
  localparam int unsigned DvdW = DataW + 7;
  localparam int unsigned CntW = 6;
  localparam int unsigned PostW = 5;

  // config register indexes
  localparam logic RegRefClock = 1'b0;
  localparam logic RegMaxError = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_POST_BIG = 2'd1,
    ST_ERR_BIG  = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIV_QUO = 2'd0,
    DIV_ACT = 2'd1,
    DIV_PCT = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_NORM,
    S_DIV2,
    S_PCT,
    S_DIV3,
    S_EVAL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_step;
    logic     save_quo;
    logic     norm_step;
    logic     save_act;
    logic     save_pct;
    logic     out_load;
    status_e  res;
  } cmd_t;

  typedef struct packed {
    logic bad_req;
    logic div_busy;
    logic norm_more;
    logic post_over;
    logic err_over;
  } stat_t;

endpackage

// ----- rtl/core/spicd_dp.sv -----
// Datapath: config registers, shared restoring divider, normalization and result registers.
module spicd_dp #(
  parameter int unsigned PRE_DIV_LIMIT = 16,
  parameter int unsigned POST_DIV_MAX  = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [31:0]           target_speed_hz_i,
  input  spicd_pkg::cmd_t       cmd_i,
  output spicd_pkg::stat_t      stat_o,
  output logic [1:0]            status_o,
  output logic [3:0]            pre_field_o,
  output logic [3:0]            post_field_o,
  output logic [31:0]           actual_speed_hz_o,
  output logic [7:0]            error_percent_o
);

  localparam int unsigned DW = spicd_pkg::DvdW;
  localparam int unsigned QW = spicd_pkg::DataW;

  logic [QW-1:0]                 ref_q;
  logic [spicd_pkg::ErrW-1:0]    maxerr_q;

  logic [QW-1:0]                 target_q;
  logic [QW-1:0]                 div_q, div_d;
  logic [spicd_pkg::PostW-1:0]   post_q, post_d;
  logic [QW-1:0]                 actual_q;
  logic [DW-1:0]                 pct_q;

  logic [DW-1:0]                 dvd_q, dvd_d;
  logic [QW:0]                   rem_q, rem_d;
  logic [QW-1:0]                 dvsr_q, dvsr_d;
  logic [spicd_pkg::CntW-1:0]    cnt_q, cnt_d;

  spicd_pkg::status_e            st_q;
  logic [3:0]                    pre_q, postf_q;
  logic [QW-1:0]                 act_out_q;
  logic [7:0]                    err_out_q;

  logic [QW-1:0]                 diff;
  logic [DW-1:0]                 prod;
  logic [QW:0]                   rem_sh;
  logic                          ge;
  logic [7:0]                    pct_sat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= 32'd60000000;
      maxerr_q <= 7'd10;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == spicd_pkg::RegRefClock) begin
        ref_q <= cfg_data_i;
      end else begin
        maxerr_q <= cfg_data_i[spicd_pkg::ErrW-1:0];
      end
    end
  end

  assign diff = (target_q > actual_q) ? (target_q - actual_q) : (actual_q - target_q);
  assign prod = DW'({7'd0, diff} * DW'(spicd_pkg::PctScale));

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh = {rem_q[QW-1:0], dvd_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    cnt_d  = cnt_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      case (cmd_i.div_sel)
        spicd_pkg::DIV_QUO: begin
          dvd_d  = {ref_q, 7'd0};
          dvsr_d = target_q;
          cnt_d  = spicd_pkg::CntW'(QW);
        end
        spicd_pkg::DIV_ACT: begin
          dvd_d  = {ref_q, 7'd0};
          dvsr_d = div_q;
          cnt_d  = spicd_pkg::CntW'(QW);
        end
        spicd_pkg::DIV_PCT: begin
          dvd_d  = prod;
          dvsr_d = target_q;
          cnt_d  = spicd_pkg::CntW'(DW);
        end
        default: begin
          dvd_d  = '0;
          dvsr_d = target_q;
          cnt_d  = '0;
        end
      endcase
    end else if (cmd_i.div_step) begin
      rem_d = ge ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;
      dvd_d = {dvd_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    div_d  = div_q;
    post_d = post_q;
    if (cmd_i.save_quo) begin
      div_d  = dvd_q[QW-1:0];
      post_d = '0;
    end else if (cmd_i.norm_step) begin
      div_d  = div_q >> 1;
      post_d = post_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    div_q  <= div_d;
    post_q <= post_d;
    if (cmd_i.load) begin
      target_q <= target_speed_hz_i;
    end
    if (cmd_i.save_act) begin
      actual_q <= dvd_q[QW-1:0] >> post_q;
    end
    if (cmd_i.save_pct) begin
      pct_q <= dvd_q;
    end
  end

  assign pct_sat = (|pct_q[DW-1:8]) ? 8'hFF : pct_q[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      st_q      <= cmd_i.res;
      pre_q     <= '0;
      postf_q   <= '0;
      act_out_q <= '0;
      err_out_q <= '0;
      if (cmd_i.res == spicd_pkg::ST_OK) begin
        pre_q   <= 4'(div_q - 32'd1);
        postf_q <= post_q[3:0];
      end
      if (cmd_i.res == spicd_pkg::ST_OK || cmd_i.res == spicd_pkg::ST_ERR_BIG) begin
        act_out_q <= actual_q;
        err_out_q <= pct_sat;
      end
    end
  end

  assign stat_o.bad_req   = (target_q == '0) || (target_q > ref_q);
  assign stat_o.div_busy  = (cnt_q != '0);
  assign stat_o.norm_more = (div_q >= QW'(PRE_DIV_LIMIT));
  assign stat_o.post_over = (post_q > spicd_pkg::PostW'(POST_DIV_MAX));
  assign stat_o.err_over  = (pct_q > DW'(maxerr_q));

  assign status_o          = st_q;
  assign pre_field_o       = pre_q;
  assign post_field_o      = postf_q;
  assign actual_speed_hz_o = act_out_q;
  assign error_percent_o   = err_out_q;

endmodule

// ----- rtl/core/spicd_ctrl.sv -----
// Controller: sequences the check, three divisions, normalization and result hand-off.
module spicd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spicd_pkg::stat_t  stat_i,
  output spicd_pkg::cmd_t   cmd_o
);

  spicd_pkg::state_e  state_q, state_d;
  spicd_pkg::status_e res_q, res_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spicd_pkg::S_IDLE;
      res_q       <= spicd_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.res   = res_q;
    in_ready_o  = 1'b0;
    case (state_q)
      spicd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = spicd_pkg::S_CHECK;
        end
      end
      spicd_pkg::S_CHECK: begin
        if (stat_i.bad_req) begin
          res_d   = spicd_pkg::ST_INVALID;
          state_d = spicd_pkg::S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = spicd_pkg::DIV_QUO;
          state_d         = spicd_pkg::S_DIV1;
        end
      end
      spicd_pkg::S_DIV1: begin
        if (stat_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.save_quo = 1'b1;
          state_d        = spicd_pkg::S_NORM;
        end
      end
      spicd_pkg::S_NORM: begin
        if (stat_i.norm_more) begin
          cmd_o.norm_step = 1'b1;
        end else if (stat_i.post_over) begin
          res_d   = spicd_pkg::ST_POST_BIG;
          state_d = spicd_pkg::S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = spicd_pkg::DIV_ACT;
          state_d         = spicd_pkg::S_DIV2;
        end
      end
      spicd_pkg::S_DIV2: begin
        if (stat_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.save_act = 1'b1;
          state_d        = spicd_pkg::S_PCT;
        end
      end
      spicd_pkg::S_PCT: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = spicd_pkg::DIV_PCT;
        state_d         = spicd_pkg::S_DIV3;
      end
      spicd_pkg::S_DIV3: begin
        if (stat_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.save_pct = 1'b1;
          state_d        = spicd_pkg::S_EVAL;
        end
      end
      spicd_pkg::S_EVAL: begin
        res_d   = stat_i.err_over ? spicd_pkg::ST_ERR_BIG : spicd_pkg::ST_OK;
        state_d = spicd_pkg::S_FIN;
      end
      spicd_pkg::S_FIN: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = spicd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spicd_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/spi_clock_divider_search_top.sv -----
// Prescaler halvings run one per cycle between the first and second division; an invalid
// request or an oversized power divider skips the remaining divisions.
// The shared restoring divider takes 32 + 32 + 39 one-bit steps per request.
// One request at a time; a result waiting on out_ready_i sits in the output register and does
// not block the next request.
// Reset: asynchronous active low; controller idles, ref clock 60 MHz, max error 10 percent.
module spi_clock_divider_search_top #(
  parameter int unsigned PRE_DIV_LIMIT = 16,
  parameter int unsigned POST_DIV_MAX  = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] target_speed_hz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  pre_field_o,
  output logic [3:0]  post_field_o,
  output logic [31:0] actual_speed_hz_o,
  output logic [7:0]  error_percent_o
);

  spicd_pkg::cmd_t  cmd;
  spicd_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  spicd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spicd_dp #(
    .PRE_DIV_LIMIT (PRE_DIV_LIMIT),
    .POST_DIV_MAX  (POST_DIV_MAX)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .target_speed_hz_i (target_speed_hz_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .pre_field_o       (pre_field_o),
    .post_field_o      (post_field_o),
    .actual_speed_hz_o (actual_speed_hz_o),
    .error_percent_o   (error_percent_o)
  );

`ifndef SYNTH
  // one request in flight: no second request right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // rejected settings report no divider fields
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != spicd_pkg::ST_OK)
    |-> (pre_field_o == 4'd0 && post_field_o == 4'd0))
    else $error("divider fields nonzero on rejected request");

  // invalid request or oversized power divider report no speed or error
  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == spicd_pkg::ST_INVALID || status_o == spicd_pkg::ST_POST_BIG))
    |-> (actual_speed_hz_o == 32'd0 && error_percent_o == 8'd0))
    else $error("speed or error reported for invalid setting");
`endif

endmodule
